FILE: rtl/fdm_pkg.sv
// Command codes, dot modes and decimal split helpers for the display multiplexer.
`default_nettype none

package fdm_pkg;

	localparam int NumDigits = 4;

	localparam logic [2:0] CMD_LOAD_BYTE = 3'd0;
	localparam logic [2:0] CMD_LOAD_INT  = 3'd1;
	localparam logic [2:0] CMD_SET_DOT   = 3'd2;
	localparam logic [2:0] CMD_SET_PLACE = 3'd3;
	localparam logic [2:0] CMD_PLACE_DOT = 3'd4;
	localparam logic [2:0] CMD_SCAN_TICK = 3'd5;

	localparam logic [1:0] DOT_OFF    = 2'd0;
	localparam logic [1:0] DOT_ON     = 2'd1;
	localparam logic [1:0] DOT_TOGGLE = 2'd2;
	localparam logic [1:0] DOT_KEEP   = 2'd3;

	localparam logic [13:0] MAX_VALUE = 14'd9999;

	// Fields that travel with a word down the pipeline.
	typedef struct packed {
		logic [2:0] cmd;
		logic [1:0] index;
		logic [1:0] dot_mode;
	} ctl_t;

	// Leading decimal digit of v for a power of ten base, with v below ten times base.
	function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] base);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= 14'(k) * base) begin
				n = 4'(k);
			end
		end
		return n;
	endfunction

	function automatic logic [13:0] dec_rem(input logic [13:0] v, input logic [13:0] base,
			input logic [3:0] d);
		return v - ({10'd0, d} * base);
	endfunction

	function automatic logic apply_dot(input logic cur, input logic [1:0] mode);
		logic r;
		unique case (mode)
			DOT_OFF:    r = 1'b0;
			DOT_ON:     r = 1'b1;
			DOT_TOGGLE: r = ~cur;
			DOT_KEEP:   r = cur;
			default:    r = cur;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/four_digit_display_multiplexer.sv
// Top level of the four-digit multiplexed display controller.
`default_nettype none

// Four-digit display controller with BCD output. Words are load, dot and decimal-place commands
// and scan ticks; only a scan tick returns a word, which drives one digit position (0 is the
// leftmost) and then advances the scan position. One word can be accepted every cycle while
// in_stall is low. A word passes an input register and two decimal split stages (thousands,
// then hundreds) before it takes effect on the held digits and dots, and a scan result is then
// registered in the output register. Words take effect strictly in order, so a tick always shows
// every earlier load. A waiting result does not block the pipeline: words that give no result keep
// flowing, and only a scan tick that finds the output register full and stalled holds its stage.
module four_digit_display_multiplexer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [13:0] value,
	input  wire logic [1:0]  index,
	input  wire logic [1:0]  dot_mode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       bcd_digit,
	output logic [3:0]       digit_enable,
	output logic             dot_on,
	output logic             digit_shown
);
	import fdm_pkg::*;

	// Pipeline registers.
	logic        vld_s1, vld_s2, vld_s3;
	ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [13:0] value_s1;
	logic [3:0]  th_s2, th_s3;
	logic        vis0_s2, vis0_s3;
	logic [9:0]  rem_s2;
	logic [3:0]  hu_s3;
	logic [6:0]  rem_s3;

	// Display state.
	logic [3:0] digit_q [NumDigits];
	logic [3:0] visible_q;
	logic [3:0] dot_q;
	logic [1:0] place_q;
	logic [1:0] scan_q;

	// Output register.
	logic       out_valid_q;
	logic [3:0] bcd_q;
	logic [3:0] enable_q;
	logic       dot_out_q;
	logic       shown_q;

	logic mv1, mv2, commit;
	logic is_scan_s3;

	assign is_scan_s3 = ctl_s3.cmd == CMD_SCAN_TICK;
	assign commit = vld_s3 && (!is_scan_s3 || !out_valid_q || !out_stall);
	assign mv2 = vld_s2 && (!vld_s3 || commit);
	assign mv1 = vld_s1 && (!vld_s2 || mv2);
	assign in_stall = vld_s1 && !mv1;

	// Stage 2: pick the value to split and take off the thousands digit.
	logic [13:0] sel_v;
	logic [3:0]  th_c;
	logic [13:0] rem1000_c;
	always_comb begin
		if (ctl_s1.cmd == CMD_LOAD_BYTE) begin
			sel_v = {6'd0, value_s1[7:0]};
		end else if (value_s1 > MAX_VALUE) begin
			sel_v = MAX_VALUE;
		end else begin
			sel_v = value_s1;
		end
		th_c = dec_digit(sel_v, 14'd1000);
		rem1000_c = dec_rem(sel_v, 14'd1000, th_c);
	end

	// Stage 3: hundreds digit.
	logic [3:0]  hu_c;
	logic [13:0] rem100_c;
	always_comb begin
		hu_c = dec_digit({4'd0, rem_s2}, 14'd100);
		rem100_c = dec_rem({4'd0, rem_s2}, 14'd100, hu_c);
	end

	// Commit stage: tens and ones.
	logic [3:0]  te_c;
	logic [13:0] ones_c;
	always_comb begin
		te_c = dec_digit({7'd0, rem_s3}, 14'd10);
		ones_c = dec_rem({7'd0, rem_s3}, 14'd10, te_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (mv1 || !vld_s1) begin
				vld_s1 <= in_valid;
			end
			if (mv2 || !vld_s2) begin
				vld_s2 <= mv1;
			end
			if (commit || !vld_s3) begin
				vld_s3 <= mv2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!vld_s1 || mv1) begin
			ctl_s1 <= '{cmd: cmd, index: index, dot_mode: dot_mode};
			value_s1 <= value;
		end
		if (mv1) begin
			ctl_s2 <= ctl_s1;
			th_s2 <= th_c;
			vis0_s2 <= th_c != 4'd0;
			rem_s2 <= rem1000_c[9:0];
		end
		if (mv2) begin
			ctl_s3 <= ctl_s2;
			th_s3 <= th_s2;
			vis0_s3 <= vis0_s2;
			hu_s3 <= hu_c;
			rem_s3 <= rem100_c[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumDigits; i++) begin
				digit_q[i] <= 4'd0;
			end
			visible_q <= 4'd0;
			dot_q <= 4'd0;
			place_q <= 2'd0;
			scan_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				unique case (ctl_s3.cmd)
					CMD_LOAD_BYTE, CMD_LOAD_INT: begin
						// The byte path reaches here with a zero thousands digit.
						digit_q[0] <= th_s3;
						digit_q[1] <= hu_s3;
						digit_q[2] <= te_c;
						digit_q[3] <= ones_c[3:0];
						visible_q <= {3'b111, vis0_s3};
					end
					CMD_SET_DOT: begin
						dot_q[ctl_s3.index] <= apply_dot(dot_q[ctl_s3.index], ctl_s3.dot_mode);
					end
					CMD_SET_PLACE: begin
						if (ctl_s3.index != place_q) begin
							dot_q[place_q] <= 1'b0;
							place_q <= ctl_s3.index;
						end
					end
					CMD_PLACE_DOT: begin
						dot_q[place_q] <= apply_dot(dot_q[place_q], ctl_s3.dot_mode);
					end
					CMD_SCAN_TICK: begin
						out_valid_q <= 1'b1;
						scan_q <= scan_q + 2'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && is_scan_s3) begin
			bcd_q <= digit_q[scan_q];
			enable_q <= 4'(1) << scan_q;
			dot_out_q <= dot_q[scan_q];
			shown_q <= visible_q[scan_q];
		end
	end

	assign out_valid = out_valid_q;
	assign bcd_digit = bcd_q;
	assign digit_enable = enable_q;
	assign dot_on = dot_out_q;
	assign digit_shown = shown_q;

	// Held digits are always decimal.
	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q[0] <= 4'd9 && digit_q[1] <= 4'd9 && digit_q[2] <= 4'd9 && digit_q[3] <= 4'd9)
		else $error("held digit out of decimal range");

	// Each committed tick moves the scan position by one.
	a_scan_advance: assert property (@(posedge clk) disable iff (!arst_n)
		commit && is_scan_s3 |=> scan_q == $past(scan_q) + 2'd1)
		else $error("scan position did not advance");

	// The scan position only moves on a committed tick.
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && is_scan_s3) |=> $stable(scan_q))
		else $error("scan position moved without a tick");

	// A stalled tick never overwrites a waiting result.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(commit && is_scan_s3))
		else $error("result overwritten while stalled");

	// A result always drives exactly one position.
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(enable_q))
		else $error("digit enable not one-hot");

endmodule

`default_nettype wire
